@@ src/dsfb_pkg.sv @@
package dsfb_pkg;

	localparam int CLASS_COUNT = 80;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CLASS_LAST = 8'(CLASS_COUNT - 1);

	// configuration register indexes
	localparam logic [2:0] REG_MIN_SCORE       = 3'd0;
	localparam logic [2:0] REG_LIMIT_WIDTH     = 3'd1;
	localparam logic [2:0] REG_LIMIT_HEIGHT    = 3'd2;
	localparam logic [2:0] REG_SCALE_X         = 3'd3;
	localparam logic [2:0] REG_SCALE_Y         = 3'd4;

	localparam logic [15:0] RST_MIN_SCORE       = 16'd16384;
	localparam logic [14:0] RST_LIMIT           = 15'd10240;
	localparam logic [15:0] RST_SCALE           = 16'd256;

	// round half up before dropping to Q.4
	localparam logic [32:0] EDGE_RND   = 33'd256;
	localparam logic [31:0] EXTENT_RND = 32'd128;

	typedef struct packed {
		logic [15:0] min_score;
		logic [14:0] limit_width;
		logic [14:0] limit_height;
		logic [15:0] scale_x;
		logic [15:0] scale_y;
	} cfg_t;

	// one closed anchor that passed the threshold
	typedef struct packed {
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic signed [15:0] box_w;
		logic signed [15:0] box_h;
		logic [7:0]         class_id;
		logic [15:0]        best_score;
		logic [15:0]        anchor_index;
	} det_rec_t;

endpackage

@@ src/detection_score_filter_box_decode_top.sv @@
// Detection score filter with box decode. Feed one class score per beat; the beats of
// one anchor are consecutive, and last_class (or the CLASS_COUNT-th beat) closes the
// anchor. The best score and its class are tracked as beats arrive, first maximum
// winning ties. When a closed anchor's best score reaches min_score, one result
// beat carries the corner box built from the closing beat's box fields (clamped to the
// limit extent, scaled by the Q8.8 factors, rounded and saturated), the class, the score
// and the anchor index. The input takes one beat per clock; it stalls only while the
// four-entry detection queue between the argmax front and the decode back is full.
// The decode back is a three-stage pipeline with the result register at its end.
// Configure registers only while the block is idle.
module detection_score_filter_box_decode_top (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,

	input  logic               push,
	output logic               full,
	input  logic [15:0]        class_score,
	input  logic signed [15:0] center_x,
	input  logic signed [15:0] center_y,
	input  logic signed [15:0] box_w,
	input  logic signed [15:0] box_h,
	input  logic               last_class,
	input  logic               last_anchor,

	output logic               empty,
	input  logic               pop,
	output logic [15:0]        out_x1,
	output logic [15:0]        out_y1,
	output logic [15:0]        out_w,
	output logic [15:0]        out_h,
	output logic [7:0]         class_id,
	output logic [15:0]        best_score,
	output logic [15:0]        anchor_index
);

	dsfb_pkg::cfg_t     cfg_q;
	dsfb_pkg::det_rec_t push_rec;
	dsfb_pkg::det_rec_t pop_rec;
	logic               rec_push;
	logic               rec_full;
	logic               rec_pop;
	logic               rec_empty;
	logic               cfg_wr;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_score       <= dsfb_pkg::RST_MIN_SCORE;
			cfg_q.limit_width     <= dsfb_pkg::RST_LIMIT;
			cfg_q.limit_height    <= dsfb_pkg::RST_LIMIT;
			cfg_q.scale_x         <= dsfb_pkg::RST_SCALE;
			cfg_q.scale_y         <= dsfb_pkg::RST_SCALE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				dsfb_pkg::REG_MIN_SCORE:       cfg_q.min_score       <= pwdata[15:0];
				dsfb_pkg::REG_LIMIT_WIDTH:     cfg_q.limit_width     <= pwdata[14:0];
				dsfb_pkg::REG_LIMIT_HEIGHT:    cfg_q.limit_height    <= pwdata[14:0];
				dsfb_pkg::REG_SCALE_X:         cfg_q.scale_x         <= pwdata[15:0];
				dsfb_pkg::REG_SCALE_Y:         cfg_q.scale_y         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dsfb_pkg::REG_MIN_SCORE:       prdata = {16'd0, cfg_q.min_score};
			dsfb_pkg::REG_LIMIT_WIDTH:     prdata = {17'd0, cfg_q.limit_width};
			dsfb_pkg::REG_LIMIT_HEIGHT:    prdata = {17'd0, cfg_q.limit_height};
			dsfb_pkg::REG_SCALE_X:         prdata = {16'd0, cfg_q.scale_x};
			dsfb_pkg::REG_SCALE_Y:         prdata = {16'd0, cfg_q.scale_y};
			default:                       prdata = '0;
		endcase
	end

	dsfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.class_score (class_score),
		.center_x    (center_x),
		.center_y    (center_y),
		.box_w       (box_w),
		.box_h       (box_h),
		.last_class  (last_class),
		.last_anchor (last_anchor),
		.rec_push    (rec_push),
		.rec         (push_rec),
		.rec_full    (rec_full)
	);

	dsfb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (push_rec),
		.full   (rec_full),
		.pop    (rec_pop),
		.rdata  (pop_rec),
		.empty  (rec_empty)
	);

	dsfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.rec          (pop_rec),
		.rec_empty    (rec_empty),
		.rec_pop      (rec_pop),
		.empty        (empty),
		.pop          (pop),
		.out_x1       (out_x1),
		.out_y1       (out_y1),
		.out_w        (out_w),
		.out_h        (out_h),
		.class_id     (class_id),
		.best_score   (best_score),
		.anchor_index (anchor_index)
	);

endmodule

@@ src/dsfb_front.sv @@
module dsfb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  dsfb_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic [15:0]         class_score,
	input  logic signed [15:0]  center_x,
	input  logic signed [15:0]  center_y,
	input  logic signed [15:0]  box_w,
	input  logic signed [15:0]  box_h,
	input  logic                last_class,
	input  logic                last_anchor,
	output logic                rec_push,
	output dsfb_pkg::det_rec_t  rec,
	input  logic                rec_full
);

	logic [15:0] running_max_q;
	logic [7:0]  running_class_q;
	logic [7:0]  class_counter_q;
	logic [15:0] anchor_counter_q;

	logic        accept;
	logic        take_new;
	logic [15:0] new_max;
	logic [7:0]  new_class;
	logic        close;

	assign full   = rec_full;
	assign accept = push && !rec_full;

	// first class of an anchor always takes over; later ones only on a strict gain
	assign take_new  = (class_counter_q == 8'd0) || (class_score > running_max_q);
	assign new_max   = take_new ? class_score : running_max_q;
	assign new_class = take_new ? class_counter_q : running_class_q;
	assign close     = last_class || (class_counter_q >= dsfb_pkg::CLASS_LAST);

	assign rec_push = accept && close && (new_max >= cfg.min_score);

	always_comb begin
		rec.center_x     = center_x;
		rec.center_y     = center_y;
		rec.box_w        = box_w;
		rec.box_h        = box_h;
		rec.class_id     = new_class;
		rec.best_score   = new_max;
		rec.anchor_index = anchor_counter_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_max_q    <= '0;
			running_class_q  <= '0;
			class_counter_q  <= '0;
			anchor_counter_q <= '0;
		end else if (accept) begin
			if (close) begin
				running_max_q    <= '0;
				running_class_q  <= '0;
				class_counter_q  <= '0;
				anchor_counter_q <= last_anchor ? 16'd0 : anchor_counter_q + 16'd1;
			end else begin
				running_max_q   <= new_max;
				running_class_q <= new_class;
				class_counter_q <= class_counter_q + 8'd1;
			end
		end
	end

endmodule

@@ src/dsfb_fifo.sv @@
module dsfb_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dsfb_pkg::det_rec_t wdata,
	output logic               full,
	input  logic               pop,
	output dsfb_pkg::det_rec_t rdata,
	output logic               empty
);

	dsfb_pkg::det_rec_t                 mem_q [dsfb_pkg::FIFO_DEPTH];
	logic [dsfb_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [dsfb_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [dsfb_pkg::FIFO_CNT_W-1:0]    count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = (count_q == dsfb_pkg::FIFO_CNT_W'(dsfb_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + dsfb_pkg::FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + dsfb_pkg::FIFO_PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + dsfb_pkg::FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - dsfb_pkg::FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/dsfb_back.sv @@
module dsfb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dsfb_pkg::cfg_t     cfg,
	input  dsfb_pkg::det_rec_t rec,
	input  logic               rec_empty,
	output logic               rec_pop,
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        out_x1,
	output logic [15:0]        out_y1,
	output logic [15:0]        out_w,
	output logic [15:0]        out_h,
	output logic [7:0]         class_id,
	output logic [15:0]        best_score,
	output logic [15:0]        anchor_index
);

	logic advance;

	// stage 1: clamped corner (Q.5) and size (Q.4)
	logic        v_s1;
	logic [15:0] x_s1, y_s1;
	logic [14:0] w_s1, h_s1;
	logic [7:0]  cls_s1;
	logic [15:0] score_s1, anchor_s1;

	// stage 2: raw products
	logic        v_s2;
	logic [31:0] px_s2, py_s2;
	logic [30:0] pw_s2, ph_s2;
	logic [7:0]  cls_s2;
	logic [15:0] score_s2, anchor_s2;

	// stage 3: rounded, saturated result
	logic        v_s3;

	logic signed [17:0] dx, dy;
	logic [15:0]        hx, hy;
	logic [15:0]        x_c, y_c;
	logic [14:0]        w_c, h_c;
	logic [32:0]        sx, sy;
	logic [31:0]        sw, sh;

	// whole pipeline holds while the result waits for a pop
	assign advance = !v_s3 || pop;
	assign rec_pop = advance && !rec_empty;
	assign empty   = !v_s3;

	function automatic logic [15:0] clamp_edge(logic signed [17:0] d, logic [15:0] hi);
		logic [15:0] r;
		if (d < 0) begin
			r = '0;
		end else if (d > $signed({2'b00, hi})) begin
			r = hi;
		end else begin
			r = d[15:0];
		end
		return r;
	endfunction

	function automatic logic [14:0] clamp_size(logic signed [15:0] s, logic [14:0] hi);
		logic [14:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s > $signed({1'b0, hi})) begin
			r = hi;
		end else begin
			r = s[14:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] sat16(logic [23:0] v);
		return (|v[23:16]) ? 16'hFFFF : v[15:0];
	endfunction

	always_comb begin
		dx  = 18'(rec.center_x) * 18'sd2 - 18'(rec.box_w);
		dy  = 18'(rec.center_y) * 18'sd2 - 18'(rec.box_h);
		hx  = {cfg.limit_width, 1'b0};
		hy  = {cfg.limit_height, 1'b0};
		x_c = clamp_edge(dx, hx);
		y_c = clamp_edge(dy, hy);
		w_c = clamp_size(rec.box_w, cfg.limit_width);
		h_c = clamp_size(rec.box_h, cfg.limit_height);
		sx  = {1'b0, px_s2} + dsfb_pkg::EDGE_RND;
		sy  = {1'b0, py_s2} + dsfb_pkg::EDGE_RND;
		sw  = {1'b0, pw_s2} + dsfb_pkg::EXTENT_RND;
		sh  = {1'b0, ph_s2} + dsfb_pkg::EXTENT_RND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !rec_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1      <= x_c;
			y_s1      <= y_c;
			w_s1      <= w_c;
			h_s1      <= h_c;
			cls_s1    <= rec.class_id;
			score_s1  <= rec.best_score;
			anchor_s1 <= rec.anchor_index;

			px_s2     <= 32'(x_s1) * 32'(cfg.scale_x);
			py_s2     <= 32'(y_s1) * 32'(cfg.scale_y);
			pw_s2     <= 31'(w_s1) * 31'(cfg.scale_x);
			ph_s2     <= 31'(h_s1) * 31'(cfg.scale_y);
			cls_s2    <= cls_s1;
			score_s2  <= score_s1;
			anchor_s2 <= anchor_s1;

			out_x1       <= sat16(sx[32:9]);
			out_y1       <= sat16(sy[32:9]);
			out_w        <= sat16(sw[31:8]);
			out_h        <= sat16(sh[31:8]);
			class_id     <= cls_s2;
			best_score   <= score_s2;
			anchor_index <= anchor_s2;
		end
	end

endmodule
